// ===== sv/light_pulse_byte_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// light_pulse_byte_receiver_assert.svh
// Assertion macros for the light pulse byte receiver. Each macro expects the
// module to have i_clk and an active-low synchronous reset i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LIGHT_PULSE_BYTE_RECEIVER_ASSERT_SVH
`define LIGHT_PULSE_BYTE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LPBR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpbr assertion failed");
// next-cycle implication
`define LPBR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpbr assertion failed");
`else
`define LPBR_ASSERT_IMPL(name, ante, cons)
`define LPBR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/lpbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbr_pkg
// Shared types and constants of the light pulse byte receiver.
// ----------------------------------------------------------------------------
package lpbr_pkg;

    localparam int unsigned THR_W     = 10;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BIT_IDX_W = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    localparam logic [THR_W-1:0]     THR_RESET          = 10'd615;
    localparam logic [TICK_W-1:0]    BIT_PERIOD_RESET   = 16'd1024;
    localparam logic [TICK_W-1:0]    FIRST_SAMPLE_RESET = 16'd1229;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT           = 3'd7;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_STOP = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REG_LEVEL_THRESHOLD = 2'd0,
        REG_BIT_PERIOD      = 2'd1,
        REG_FIRST_SAMPLE    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  level_threshold;
        logic [TICK_W-1:0] bit_period_ticks;
        logic [TICK_W-1:0] first_sample_ticks;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

// ===== sv/lpbr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbr_regs
// APB-style configuration registers: threshold, bit period, first sample delay.
// ----------------------------------------------------------------------------
module lpbr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpbr_pkg::ADDR_W-1:0] paddr,
    input  logic [lpbr_pkg::DATA_W-1:0] pwdata,
    output logic [lpbr_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lpbr_pkg::t_cfg              o_cfg
);
    import lpbr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold    <= THR_RESET;
            r_cfg.bit_period_ticks   <= BIT_PERIOD_RESET;
            r_cfg.first_sample_ticks <= FIRST_SAMPLE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEVEL_THRESHOLD: r_cfg.level_threshold    <= pwdata[THR_W-1:0];
                REG_BIT_PERIOD:      r_cfg.bit_period_ticks   <= pwdata[TICK_W-1:0];
                REG_FIRST_SAMPLE:    r_cfg.first_sample_ticks <= pwdata[TICK_W-1:0];
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEVEL_THRESHOLD: prdata = DATA_W'(r_cfg.level_threshold);
            REG_BIT_PERIOD:      prdata = DATA_W'(r_cfg.bit_period_ticks);
            REG_FIRST_SAMPLE:    prdata = DATA_W'(r_cfg.first_sample_ticks);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== sv/lpbr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbr_core
// Level slicer and receive sequencer: start edge hunt, data bit sampling, stop.
// ----------------------------------------------------------------------------
`include "light_pulse_byte_receiver_assert.svh"

module lpbr_core #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  lpbr_pkg::t_cfg         i_cfg,
    output lpbr_pkg::t_result      o_result
);
    import lpbr_pkg::*;

    localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    t_phase                r_phase, n_phase;
    logic                  r_prev_level, n_prev_level;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]     r_shift, n_shift;

    logic                  level;
    logic                  wait_done;
    logic                  start_edge;
    logic [BYTE_W-1:0]     shift_set;

    assign level      = CMP_W'(i_sample) >= CMP_W'(i_cfg.level_threshold);
    assign wait_done  = r_tick <= TICK_W'(1);
    assign start_edge = r_prev_level && !level;
    assign shift_set  = r_shift | (BYTE_W'(level) << r_bit_idx);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (wait_done && (r_bit_idx == LAST_BIT)) begin
                        n_phase = PH_STOP;
                    end
                end
                PH_STOP: begin
                    // end of stop time is judged with a low previous level
                    if (wait_done) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = start_edge ? PH_DATA : PH_HUNT;
            endcase
        end
    end

    // counters and shift register
    always_comb begin
        n_prev_level = r_prev_level;
        n_tick       = r_tick;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        if (i_step) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (!wait_done) begin
                        n_tick = r_tick - TICK_W'(1);
                    end else begin
                        n_shift   = shift_set;
                        n_tick    = i_cfg.bit_period_ticks;
                        n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
                    end
                end
                PH_STOP: begin
                    if (!wait_done) begin
                        n_tick = r_tick - TICK_W'(1);
                    end else begin
                        n_prev_level = level;
                    end
                end
                default: begin
                    if (start_edge) begin
                        n_tick    = i_cfg.first_sample_ticks;
                        n_bit_idx = '0;
                        n_shift   = '0;
                    end
                    n_prev_level = level;
                end
            endcase
        end
    end

    // outputs
    assign o_result.emit    = (r_phase == PH_DATA) && wait_done && (r_bit_idx == LAST_BIT);
    assign o_result.rx_byte = shift_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_prev_level <= 1'b1;
            r_tick       <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_prev_level <= n_prev_level;
            r_tick       <= n_tick;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
        end
    end

    `LPBR_ASSERT_NEXT(a_count_down, i_step && (r_phase == PH_DATA) && !wait_done, r_tick == $past(r_tick) - TICK_W'(1))
    `LPBR_ASSERT_NEXT(a_emit_to_stop, i_step && o_result.emit, (r_phase == PH_STOP) && (r_bit_idx == '0))
    `LPBR_ASSERT_IMPL(a_data_after_fall, r_phase == PH_DATA, !r_prev_level)
    `LPBR_ASSERT_NEXT(a_start_load, i_step && (r_phase == PH_HUNT) && start_edge, (r_phase == PH_DATA) && (r_tick == $past(i_cfg.first_sample_ticks)))

endmodule

// ===== sv/light_pulse_byte_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pulse_byte_receiver
// On-off keyed light receiver: slices photodiode samples, finds the start
// edge and gathers eight data bits, least significant first.
// ----------------------------------------------------------------------------
// Flow: a sample beat waits in the input register until the sequencer steps on
//   it; a completed byte goes to the result register, offered on o_rx_byte.
// Throughput: one sample beat per cycle while the result stage can take a
//   finished byte; set by the sequencer between the input and result registers.
// Reset: synchronous, active low; registers return to 615 / 1024 / 1229,
//   hunting resumes with the previous level high, both stages empty.
// ----------------------------------------------------------------------------
module light_pulse_byte_receiver #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample channel
    input  logic                        i_sample_valid,
    output logic                        o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    // byte channel
    output logic                        o_rx_valid,
    input  logic                        i_rx_ready,
    output logic [lpbr_pkg::BYTE_W-1:0] o_rx_byte,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpbr_pkg::ADDR_W-1:0] paddr,
    input  logic [lpbr_pkg::DATA_W-1:0] pwdata,
    output logic [lpbr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lpbr_pkg::*;

    // input stage: one sample beat waiting for the sequencer
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    // result stage: one byte waiting for the consumer
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;

    logic                   step;
    t_cfg                   cfg;
    t_result                result;

    // Advance the held sample unless it completes a byte and the result
    // stage is full and not being drained this cycle.
    assign step           = r_in_valid && (!result.emit || !r_out_valid || i_rx_ready);
    // Take a new beat whenever the input stage empties or moves on.
    assign o_sample_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_sample_ready) begin
            r_in_valid <= i_sample_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample_valid && o_sample_ready) begin
            r_sample <= i_sample;
        end
    end

    lpbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lpbr_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Load a finished byte; otherwise drop the valid once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rx_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.emit) begin
            r_out_byte <= result.rx_byte;
        end
    end

    assign o_rx_valid = r_out_valid;
    assign o_rx_byte  = r_out_byte;

endmodule

// ===== sim/light_pulse_byte_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pulse_byte_receiver_tb
// Self-checking bench for the light pulse byte receiver. Photodiode samples
// are shaped into start / data / stop frames with some noise and broken
// frames mixed in. A scoreboard predicts each received byte as samples are
// accepted and checks every byte beat, under several register settings and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module light_pulse_byte_receiver_tb;
    import lpbr_pkg::*;

    localparam int unsigned SAMPLE_W         = 10;
    localparam int unsigned SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
    localparam int unsigned REG_STRIDE       = 4;
    localparam int unsigned UNMAPPED_REG_IDX = 3;
    localparam int unsigned FRAME_SLOTS      = 10;   // start, eight data bits, stop
    localparam int unsigned MAX_FRAME_PERIOD = 16;
    localparam int unsigned FLUSH_SAMPLES    = 64;
    localparam int unsigned SETTLE_CYCLES    = 6;
    localparam int unsigned RX_HOLD_CYCLES   = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;
    localparam int unsigned ITEM_TARGET      = 1000;
    localparam int unsigned BYTE_TARGET      = 48;
    localparam int unsigned PHASE_ITEMS      = 80;
    localparam logic [BYTE_W-1:0] DIRECTED_BYTE_A = 8'hA5;
    localparam logic [BYTE_W-1:0] DIRECTED_BYTE_B = 8'h3C;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the receiver state, expected byte store, checks
    // ------------------------------------------------------------------------
    class rx_byte_scoreboard;
        logic [THR_W-1:0]     thr;
        logic [TICK_W-1:0]    bit_period;
        logic [TICK_W-1:0]    first_sample;
        logic                 prev_level;
        t_phase               phase;
        logic [TICK_W-1:0]    tick_count;
        logic [BIT_IDX_W-1:0] bit_index;
        logic [BYTE_W-1:0]    shift_bits;
        logic [BYTE_W-1:0]    pending_bytes[$];
        int unsigned          mismatches;
        int unsigned          predicted_count;

        function new();
            thr             = THR_RESET;
            bit_period      = BIT_PERIOD_RESET;
            first_sample    = FIRST_SAMPLE_RESET;
            prev_level      = 1'b1;
            phase           = PH_HUNT;
            tick_count      = '0;
            bit_index       = '0;
            shift_bits      = '0;
            mismatches      = 0;
            predicted_count = 0;
        endfunction

        function void write_reg(int unsigned idx, logic [DATA_W-1:0] word);
            case (idx)
                REG_LEVEL_THRESHOLD: thr          = word[THR_W-1:0];
                REG_BIT_PERIOD:      bit_period   = word[TICK_W-1:0];
                REG_FIRST_SAMPLE:    first_sample = word[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the receiver by one accepted sample beat.
        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic level;
            level = (s >= thr);
            case (phase)
                PH_DATA: begin
                    if (tick_count > 1) begin
                        tick_count--;
                        return;
                    end
                    shift_bits |= BYTE_W'(level) << bit_index;
                    tick_count  = bit_period;
                    if (bit_index == LAST_BIT) begin
                        pending_bytes.push_back(shift_bits);
                        predicted_count++;
                        bit_index = '0;
                        phase     = PH_STOP;
                    end else begin
                        bit_index++;
                    end
                    return;
                end
                PH_STOP: begin
                    if (tick_count > 1) begin
                        tick_count--;
                        return;
                    end
                    // the tick that ends the stop time is a hunt tick with a low history
                    prev_level = 1'b0;
                end
                default: ;
            endcase
            phase = PH_HUNT;
            if (prev_level && !level) begin
                phase      = PH_DATA;
                tick_count = first_sample;
                bit_index  = '0;
                shift_bits = '0;
            end
            prev_level = level;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_byte(input logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte 0x%02h", got));
                return;
            end
            want = pending_bytes.pop_front();
            if (got !== want)
                report_mismatch($sformatf("rx_byte 0x%02h, expected 0x%02h", got, want));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_sample_valid;
    logic                o_sample_ready;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_rx_valid;
    logic                i_rx_ready;
    logic [BYTE_W-1:0]   o_rx_byte;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    rx_byte_scoreboard sb = new();

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned noise_pct;
    int unsigned items_sent;
    bit          rx_hold_req;

    always #10 i_clk = ~i_clk;

    light_pulse_byte_receiver #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_rx_valid     (o_rx_valid),
        .i_rx_ready     (i_rx_ready),
        .o_rx_byte      (o_rx_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Sample channel driver
    // ------------------------------------------------------------------------

    // Offer one sample beat; hold valid and payload until it is taken.
    // Entered and left at a falling edge, so valid is never dropped and
    // raised within the same step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (o_sample_ready !== 1'b1);
        sb.note_sample(s);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and leave the channel quiet until the next falling edge.
    task automatic tx_quiet();
        i_sample_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold the line high long enough for any frame still in progress to run
    // through its stop time, so a long bit period never lands mid-byte.
    task automatic flush_frame();
        repeat (FLUSH_SAMPLES) send_sample(SAMPLE_W'(SAMPLE_MAX));
    endtask

    // Pick a raw reading for a light level, sometimes right on the threshold
    // boundary, sometimes pure noise.
    function automatic logic [SAMPLE_W-1:0] level_sample(input logic level);
        int unsigned thr_now;
        int unsigned roll;
        thr_now = sb.thr;
        roll    = $urandom_range(99, 0);
        if (roll < noise_pct)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        if (level)
            return SAMPLE_W'((roll < 15) ? thr_now : $urandom_range(SAMPLE_MAX, thr_now));
        if (thr_now == 0)
            return '0;
        return SAMPLE_W'((roll < 15) ? thr_now - 1 : $urandom_range(thr_now - 1, 0));
    endfunction

    // Send a frame at the current bit period: idle high, start low, eight
    // data bits LSB first, stop high. Cut it short at slot cut_at to give a
    // broken frame.
    task automatic send_frame(input logic [BYTE_W-1:0] data, input int unsigned cut_at);
        int unsigned period;
        int unsigned slot;
        logic        level;
        period = (sb.bit_period == 0) ? 1 : sb.bit_period;
        repeat ($urandom_range(3, 1)) send_sample(level_sample(1'b1));
        for (slot = 0; slot < FRAME_SLOTS; slot++) begin
            if (slot == cut_at)
                return;
            level = (slot == 0) ? 1'b0 : (slot == FRAME_SLOTS - 1) ? 1'b1 : data[slot-1];
            repeat (period) send_sample(level_sample(level));
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // Two-phase register write; bits above the register width carry junk at
    // random, which the block must drop.
    task automatic cfg_write(input int unsigned idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep_mask;
        logic [DATA_W-1:0] word;
        keep_mask = (idx == REG_LEVEL_THRESHOLD) ? DATA_W'((1 << THR_W) - 1)
                                                 : DATA_W'((1 << TICK_W) - 1);
        word = value & keep_mask;
        if ($urandom_range(1, 0) == 1)
            word |= $urandom() & ~keep_mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Quiet the sender, let every expected byte drain, then let the last
    // sample beats work through the pipeline.
    task automatic settle_idle();
        tx_quiet();
        while (sb.pending_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        tx_idle_pct  = (mode == IDLE_TX) ? 53 : (mode == IDLE_BOTH) ? 21 : 0;
        rx_stall_pct = (mode == IDLE_RX) ? 53 : (mode == IDLE_BOTH) ? 21 : 0;
    endtask

    // One setting of the registers followed by a run of frames, noise bursts
    // and broken frames. Long bit periods get noise only, to keep the run short.
    task automatic run_phase(input int unsigned thr, input int unsigned period,
                             input int unsigned first, input t_idle_mode mode,
                             input int unsigned n_items, input bit hold_rx,
                             input bit pause_tx);
        int unsigned stop_at;
        int unsigned roll;
        bit          paused;
        if (period > MAX_FRAME_PERIOD)
            flush_frame();
        settle_idle();
        cfg_write(REG_LEVEL_THRESHOLD, thr);
        cfg_write(REG_BIT_PERIOD, period);
        cfg_write(REG_FIRST_SAMPLE, first);
        set_idling(mode);
        stop_at = items_sent + n_items;
        paused  = 1'b0;
        if (hold_rx)
            rx_hold_req = 1'b1;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99, 0);
            if (pause_tx && !paused && items_sent + n_items / 2 >= stop_at) begin
                // hold the sender back until every expected byte has come out
                tx_quiet();
                while (sb.pending_bytes.size() != 0)
                    @(negedge i_clk);
                paused = 1'b1;
            end else if (sb.bit_period > MAX_FRAME_PERIOD || roll < 10) begin
                repeat ($urandom_range(6, 1))
                    send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
            end else if (roll < 20) begin
                send_frame(BYTE_W'($urandom_range(255, 0)), $urandom_range(FRAME_SLOTS - 1, 0));
            end else begin
                send_frame(BYTE_W'($urandom_range(255, 0)), FRAME_SLOTS);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte channel: ready pattern, long hold-off and result checking
    // ------------------------------------------------------------------------
    initial begin : rx_ready_gen
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_rx_ready <= 1'b0;
                hold_left--;
            end else begin
                i_rx_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_rx_valid === 1'b1 && i_rx_ready === 1'b1)
            sb.check_byte(o_rx_byte);
    end

    // Give up when neither channel nor the register port moves for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_sample_valid === 1'b1 && o_sample_ready === 1'b1) ||
                (o_rx_valid === 1'b1 && i_rx_ready === 1'b1) || psel === 1'b1 ||
                i_rst_n !== 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned i;
        int unsigned phase_no;
        int unsigned period;

        i_rst_n        = 1'b0;
        i_sample_valid = 1'b0;
        i_sample       = '0;
        i_rx_ready     = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_hold_req    = 1'b0;
        items_sent     = 0;
        noise_pct      = 0;
        set_idling(IDLE_NONE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero bit period and first-sample delay act as one tick,
        // data bits right on either side of the threshold, extreme readings.
        cfg_write(REG_LEVEL_THRESHOLD, THR_RESET);
        cfg_write(REG_BIT_PERIOD, 0);
        cfg_write(REG_FIRST_SAMPLE, 0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        for (i = 0; i < BYTE_W; i++)
            send_sample(DIRECTED_BYTE_A[i] ? THR_RESET : THR_RESET - THR_W'(1));
        // low reading on the tick that ends the stop time: must not start a byte
        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        for (i = 0; i < BYTE_W; i++)
            send_sample(DIRECTED_BYTE_B[i] ? SAMPLE_W'(SAMPLE_MAX) : '0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));

        // Fixed settings, the register extremes among them.
        noise_pct = 3;
        run_phase(THR_RESET, 1, 1, IDLE_NONE, 120, 1'b0, 1'b0);
        run_phase(SAMPLE_MAX, 3, 4, IDLE_TX, 120, 1'b0, 1'b0);
        run_phase(0, 65535, 65535, IDLE_RX, 40, 1'b0, 1'b0);
        settle_idle();
        cfg_write(UNMAPPED_REG_IDX, $urandom());
        run_phase(1, 2, 3, IDLE_BOTH, 100, 1'b0, 1'b0);
        run_phase($urandom_range(SAMPLE_MAX, 1), 4, 6, IDLE_NONE, 150, 1'b1, 1'b0);
        run_phase(512, 2, 1, IDLE_TX, 100, 1'b0, 1'b1);

        // Random settings, rotating the idling pattern, until enough bytes.
        phase_no = 0;
        while (items_sent < ITEM_TARGET || sb.predicted_count < BYTE_TARGET) begin
            period = $urandom_range(4, 0);
            run_phase($urandom_range(SAMPLE_MAX, 0), period, $urandom_range(2 * period + 1, 0),
                      t_idle_mode'(phase_no % 4), PHASE_ITEMS, 1'b0, 1'b0);
            phase_no++;
        end

        settle_idle();
        if (sb.pending_bytes.size() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never arrived",
                                         sb.pending_bytes.size()));
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
